>>> rtl/trc_pkg.sv
// Shared types, codes and widths for the timed relay pair block.
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

    localparam int TIME_W     = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int IN_BITS    = 1 + 2 * TIME_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int RES_BITS   = 7;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = 2;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_MIN_DURATION   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_MAX       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAN_MAX        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PUMP_COOLDOWN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_RELAY_ACT_LOW  = 3'd4;

    localparam logic [TIME_W-1:0] MIN_DURATION_RST  = 32'd1000;
    localparam logic [TIME_W-1:0] PUMP_MAX_RST      = 32'd30000;
    localparam logic [TIME_W-1:0] FAN_MAX_RST       = 32'd600000;
    localparam logic [TIME_W-1:0] PUMP_COOLDOWN_RST = 32'd60000;

    typedef enum logic [1:0] {
        CMD_TICK     = 2'd0,
        CMD_PUMP     = 2'd1,
        CMD_FAN      = 2'd2,
        CMD_STOP_ALL = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_RANGE    = 2'd1,
        STATUS_COOLDOWN = 2'd2
    } status_t;

    typedef struct packed {
        logic [TIME_W-1:0] min_duration;
        logic [TIME_W-1:0] pump_max;
        logic [TIME_W-1:0] fan_max;
        logic [TIME_W-1:0] pump_cooldown;
        logic              relay_active_low;
    } cfg_t;

    typedef struct packed {
        cmd_t              command;
        logic              turn_on;
        logic [TIME_W-1:0] duration_ms;
        logic [TIME_W-1:0] now_ms;
    } item_t;

    // Declared from the top bit down so that accepted lands in bit 0.
    typedef struct packed {
        logic    fan_pin;
        logic    pump_pin;
        logic    fan_running;
        logic    pump_running;
        status_t status;
        logic    accepted;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/trc_cfg_regs.sv
// Configuration register file for the relay timing limits and pin polarity.
`timescale 1ns / 1ps
`default_nettype none

module trc_cfg_regs (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trc_pkg::TIME_W-1:0]     cfg_wdata,
    output trc_pkg::cfg_t                       cfg
);
    import trc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_MIN_DURATION:  cfg_next.min_duration     = cfg_wdata;
                REG_PUMP_MAX:      cfg_next.pump_max         = cfg_wdata;
                REG_FAN_MAX:       cfg_next.fan_max          = cfg_wdata;
                REG_PUMP_COOLDOWN: cfg_next.pump_cooldown    = cfg_wdata;
                REG_RELAY_ACT_LOW: cfg_next.relay_active_low = cfg_wdata[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_duration     <= MIN_DURATION_RST;
            cfg_reg.pump_max         <= PUMP_MAX_RST;
            cfg_reg.fan_max          <= FAN_MAX_RST;
            cfg_reg.pump_cooldown    <= PUMP_COOLDOWN_RST;
            cfg_reg.relay_active_low <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

>>> rtl/trc_core.sv
// Relay state registers and the per-request decision logic.
`timescale 1ns / 1ps
`default_nettype none

module trc_core (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     fire,
    input  wire trc_pkg::item_t item,
    input  wire trc_pkg::cfg_t  cfg,
    output trc_pkg::result_t result
);
    import trc_pkg::*;

    logic              pump_active_reg, pump_active_next;
    logic              fan_active_reg, fan_active_next;
    logic [TIME_W-1:0] pump_stop_reg, pump_stop_next;
    logic [TIME_W-1:0] fan_stop_reg, fan_stop_next;
    logic [TIME_W-1:0] last_start_reg, last_start_next;

    logic              pump_in_range;
    logic              fan_in_range;
    logic              cooldown_hit;
    logic              pump_expired;
    logic              fan_expired;
    logic [TIME_W-1:0] since_start;
    logic [TIME_W-1:0] fan_dur;
    logic              acc;
    status_t           st;

    assign pump_in_range = (item.duration_ms >= cfg.min_duration) &&
                           (item.duration_ms <= cfg.pump_max);
    assign fan_in_range  = (item.duration_ms >= cfg.min_duration) &&
                           (item.duration_ms <= cfg.fan_max);
    assign since_start   = item.now_ms - last_start_reg;
    // A start stamped at time zero never counts toward the cooldown.
    assign cooldown_hit  = (last_start_reg != '0) && (since_start < cfg.pump_cooldown);
    assign fan_dur       = (item.duration_ms == '0) ? cfg.fan_max : item.duration_ms;
    // An off time of zero means no timeout, so ticks leave that relay alone.
    assign pump_expired  = pump_active_reg && (pump_stop_reg != '0) &&
                           (item.now_ms >= pump_stop_reg);
    assign fan_expired   = fan_active_reg && (fan_stop_reg != '0) &&
                           (item.now_ms >= fan_stop_reg);

    always_comb begin
        pump_active_next = pump_active_reg;
        fan_active_next  = fan_active_reg;
        pump_stop_next   = pump_stop_reg;
        fan_stop_next    = fan_stop_reg;
        last_start_next  = last_start_reg;
        acc              = 1'b1;
        st               = STATUS_OK;
        unique case (item.command)
            CMD_TICK: begin
                acc = pump_expired || fan_expired;
                if (pump_expired) begin
                    pump_active_next = 1'b0;
                    pump_stop_next   = '0;
                end
                if (fan_expired) begin
                    fan_active_next = 1'b0;
                    fan_stop_next   = '0;
                end
            end
            CMD_PUMP: begin
                if (!item.turn_on) begin
                    pump_active_next = 1'b0;
                    pump_stop_next   = '0;
                end else if (!pump_in_range) begin
                    acc = 1'b0;
                    st  = STATUS_RANGE;
                end else if (cooldown_hit) begin
                    acc = 1'b0;
                    st  = STATUS_COOLDOWN;
                end else begin
                    pump_active_next = 1'b1;
                    pump_stop_next   = item.now_ms + item.duration_ms;
                    last_start_next  = item.now_ms;
                end
            end
            CMD_FAN: begin
                if (!item.turn_on) begin
                    fan_active_next = 1'b0;
                    fan_stop_next   = '0;
                end else if ((item.duration_ms != '0) && !fan_in_range) begin
                    acc = 1'b0;
                    st  = STATUS_RANGE;
                end else begin
                    fan_active_next = 1'b1;
                    fan_stop_next   = item.now_ms + fan_dur;
                end
            end
            CMD_STOP_ALL: begin
                pump_active_next = 1'b0;
                fan_active_next  = 1'b0;
                pump_stop_next   = '0;
                fan_stop_next    = '0;
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    always_comb begin
        result.accepted     = acc;
        result.status       = st;
        result.pump_running = pump_active_next;
        result.fan_running  = fan_active_next;
        result.pump_pin     = pump_active_next ^ cfg.relay_active_low;
        result.fan_pin      = fan_active_next ^ cfg.relay_active_low;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pump_active_reg <= 1'b0;
            fan_active_reg  <= 1'b0;
            pump_stop_reg   <= '0;
            fan_stop_reg    <= '0;
            last_start_reg  <= '0;
        end else if (fire) begin
            pump_active_reg <= pump_active_next;
            fan_active_reg  <= fan_active_next;
            pump_stop_reg   <= pump_stop_next;
            fan_stop_reg    <= fan_stop_next;
            last_start_reg  <= last_start_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/timed_relay_pair_with_cooldown.sv
// Top level of the timed pump and fan relay controller with pump cooldown.
//
// Usage: each request on the slave stream carries a command in s_tuser
// (tick, pump, fan, stop all) and the on flag, duration and millisecond
// timestamp in s_tdata. Every request yields exactly one result on the
// master stream: accepted, status, the two logical relay states and the two
// relay pin levels after the polarity setting is applied.
// Limits and polarity are set through the plain write port (cfg_wr_en,
// cfg_index, cfg_wdata) while no request is in flight.
//
// A request is captured in the input register at the accepting edge, then
// evaluated by one subtract, two adds and a few compares against the relay
// state; the result enters the output register once that register is free
// or being emptied, and the relay state updates with it. Throughput is one
// request per cycle while the receiver does not stall; the state update closes
// in that one evaluation step, so the next request sees it without a bubble.
//
// Reset clears the relay states, off times and last start stamp, and loads
// the default limits. When the receiver stalls, the result holds in the
// output register, one more request may wait in the input register, and
// then s_tready drops until m_tready returns.
`timescale 1ns / 1ps
`default_nettype none

module timed_relay_pair_with_cooldown (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input request stream.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // s_tdata from bit 0 up: turn_on, duration_ms[31:0], now_ms[31:0], zero fill.
    input  wire logic [trc_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser from bit 0 up: command[1:0].
    input  wire logic [trc_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result stream.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // m_tdata from bit 0 up: accepted, status[1:0], pump_running, fan_running,
    // pump_pin, fan_pin, zero fill.
    output logic [trc_pkg::M_TDATA_W-1:0]       m_tdata,
    // Configuration write port.
    input  wire logic                           cfg_wr_en,
    input  wire logic [trc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [trc_pkg::TIME_W-1:0]     cfg_wdata
);
    import trc_pkg::*;

    cfg_t    cfg;
    item_t   item_reg;
    logic    in_valid_reg;
    logic    out_valid_reg;
    result_t result;
    result_t result_reg;
    logic    core_fire;
    logic    s_accept;

    trc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // The held request is evaluated as soon as the output register is free
    // or is being emptied in the same cycle.
    assign core_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || core_fire;
    assign s_accept  = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (core_fire) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.command     <= cmd_t'(s_tuser[1:0]);
            item_reg.turn_on     <= s_tdata[0];
            item_reg.duration_ms <= s_tdata[TIME_W:1];
            item_reg.now_ms      <= s_tdata[2*TIME_W:TIME_W+1];
        end
    end

    trc_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (core_fire),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (core_fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_fire) begin
            result_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - RES_BITS){1'b0}}, result_reg};

endmodule

`default_nettype wire

>>> rtl/trc_checker.sv
// Port-level checks on the result stream of the relay controller, with bind.
`timescale 1ns / 1ps
`default_nettype none

module trc_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [trc_pkg::M_TDATA_W-1:0] m_tdata
);
    import trc_pkg::*;

    // A stalled result stays offered and unchanged.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or vanished while stalled");

    // Both pins follow their relay state through the same polarity.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_tdata[5] ^ m_tdata[3]) == (m_tdata[6] ^ m_tdata[4])))
        else $error("pump and fan pins use different polarity");

    // A rejection code never comes with an accepted request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[2:1] != STATUS_OK) |-> !m_tdata[0])
        else $error("nonzero status on an accepted request");

    // The unused status code never appears.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:1] != 2'd3))
        else $error("undefined status code");

    // Reset empties the output register.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

endmodule

bind timed_relay_pair_with_cooldown trc_checker u_trc_checker (.*);

`default_nettype wire
